// ===== src/four_level_page_walker_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four-level page walker.
// Shared helpers that wrap concurrent assertions with clock and reset.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_WALKER_TOP_MACROS_SVH
`define FOUR_LEVEL_PAGE_WALKER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPW_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page walker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page walker assertion failed");

`endif

// ===== src/fpw_pkg.sv =====
// ----------------------------------------------------------------------------
// Four-level page walker package
// Shared types and constants for the front end, queue and walk engine.
// ----------------------------------------------------------------------------
package fpw_pkg;

    typedef enum logic
    {
        OP_TRANSLATE = 1'b0,
        OP_RESPONSE  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        WS_IDLE,
        WS_L0,
        WS_L1,
        WS_L2,
        WS_L3
    } walk_state_t;

    // For a translate request, data holds the first entry address.
    // For a response, data holds the returned table entry.
    typedef struct packed
    {
        op_t         op;
        logic [63:0] data;
        logic [47:0] vaddr;
    } queue_item_t;

    typedef struct packed
    {
        logic valid;
        logic full;
    } queue_status_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] BASE_CLEAR_MASK = ~64'hF;

endpackage

// ===== src/fpw_front.sv =====
// ----------------------------------------------------------------------------
// Page walker front end
// Accepts transactions, classifies them and precomputes the first entry
// address of a translate request before it enters the queue.
// ----------------------------------------------------------------------------
module fpw_front
(
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  op,
    input  logic [63:0]           table_base,
    input  logic [47:0]           virt_addr,
    input  logic [63:0]           read_data,
    input  fpw_pkg::queue_status_t q_status,
    output logic                  q_push,
    output fpw_pkg::queue_item_t  q_item
);

    logic [63:0] first_addr;

    assign item_stall = q_status.full;
    assign q_push     = item_valid && !q_status.full;
    assign first_addr = (table_base & fpw_pkg::BASE_CLEAR_MASK)
                      + {52'd0, virt_addr[47:39], 3'b000};

    always_comb
    begin
        q_item.op    = fpw_pkg::op_t'(op);
        q_item.vaddr = virt_addr;
        if (fpw_pkg::op_t'(op) == fpw_pkg::OP_RESPONSE)
        begin
            q_item.data = read_data;
        end
        else
        begin
            q_item.data = first_addr;
        end
    end

endmodule

// ===== src/fpw_queue.sv =====
// ----------------------------------------------------------------------------
// Page walker decoupling queue
// Small first-in first-out buffer between the front end and the walk engine.
// ----------------------------------------------------------------------------
`include "four_level_page_walker_top_macros.svh"

module fpw_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fpw_pkg::queue_item_t   push_item,
    input  logic                   pop,
    output fpw_pkg::queue_item_t   head_item,
    output fpw_pkg::queue_status_t status
);

    fpw_pkg::queue_item_t                mem_reg [fpw_pkg::QUEUE_DEPTH];
    logic [fpw_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [fpw_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [fpw_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [fpw_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [fpw_pkg::QUEUE_PTR_W:0]       count_reg;
    logic [fpw_pkg::QUEUE_PTR_W:0]       count_next;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == (fpw_pkg::QUEUE_PTR_W+1)'(fpw_pkg::QUEUE_DEPTH));
    assign head_item    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + fpw_pkg::QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + fpw_pkg::QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (fpw_pkg::QUEUE_PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (fpw_pkg::QUEUE_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `FPW_ASSERT_SAME(a_no_push_when_full, clk, rst_n, status.full, !push)
    `FPW_ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, !status.valid, !pop)

endmodule

// ===== src/fpw_back.sv =====
// ----------------------------------------------------------------------------
// Page walker walk engine
// Consumes queued transactions, tracks the walk level and drives the
// registered result channel.
// ----------------------------------------------------------------------------
`include "four_level_page_walker_top_macros.svh"

module fpw_back
#(
    parameter int PHYS_MASK_BITS = 36
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  fpw_pkg::queue_item_t q_item,
    output logic                 q_pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic                 is_done,
    output logic [63:0]          read_addr,
    output logic [51:0]          xlat_addr,
    output logic                 fault
);

    localparam logic [63:0] ENTRY_MASK = ((64'd1 << PHYS_MASK_BITS) - 64'd1) & ~64'hFFF;

    fpw_pkg::walk_state_t state_reg;
    fpw_pkg::walk_state_t state_next;
    logic [47:0]          vaddr_reg;
    logic [47:0]          vaddr_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 done_reg;
    logic [63:0]          addr_reg;
    logic [51:0]          phys_reg;
    logic                 fault_reg;

    logic                 produce;
    logic                 res_done;
    logic [63:0]          res_addr;
    logic [51:0]          res_phys;
    logic                 res_fault;
    logic                 out_free;
    logic                 load;
    logic [63:0]          entry;
    logic [63:0]          frame;
    logic [63:0]          sum_2m;
    logic [63:0]          sum_4k;

    assign entry    = q_item.data;
    assign frame    = entry & ENTRY_MASK;
    assign sum_2m   = frame + {43'd0, vaddr_reg[20:0]};
    assign sum_4k   = frame + {52'd0, vaddr_reg[11:0]};
    assign out_free = !valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        vaddr_next = vaddr_reg;
        produce    = 1'b0;
        res_done   = 1'b0;
        res_addr   = '0;
        res_phys   = '0;
        res_fault  = 1'b0;
        if (q_item.op == fpw_pkg::OP_TRANSLATE)
        begin
            if (state_reg == fpw_pkg::WS_IDLE)
            begin
                produce    = 1'b1;
                res_addr   = q_item.data;
                vaddr_next = q_item.vaddr;
                state_next = fpw_pkg::WS_L0;
            end
        end
        else
        begin
            case (state_reg)
                fpw_pkg::WS_IDLE:
                begin
                    produce = 1'b0;
                end
                fpw_pkg::WS_L0:
                begin
                    produce = 1'b1;
                    if (!entry[0])
                    begin
                        res_done   = 1'b1;
                        res_fault  = 1'b1;
                        state_next = fpw_pkg::WS_IDLE;
                    end
                    else
                    begin
                        res_addr   = frame + {52'd0, vaddr_reg[38:30], 3'b000};
                        state_next = fpw_pkg::WS_L1;
                    end
                end
                fpw_pkg::WS_L1:
                begin
                    produce = 1'b1;
                    if (!entry[0])
                    begin
                        res_done   = 1'b1;
                        res_fault  = 1'b1;
                        state_next = fpw_pkg::WS_IDLE;
                    end
                    else if (entry[7])
                    begin
                        res_done   = 1'b1;
                        res_phys   = {entry[51:30], vaddr_reg[29:0]};
                        state_next = fpw_pkg::WS_IDLE;
                    end
                    else
                    begin
                        res_addr   = frame + {52'd0, vaddr_reg[29:21], 3'b000};
                        state_next = fpw_pkg::WS_L2;
                    end
                end
                fpw_pkg::WS_L2:
                begin
                    produce = 1'b1;
                    if (!entry[0])
                    begin
                        res_done   = 1'b1;
                        res_fault  = 1'b1;
                        state_next = fpw_pkg::WS_IDLE;
                    end
                    else if (entry[7])
                    begin
                        res_done   = 1'b1;
                        res_phys   = sum_2m[51:0];
                        state_next = fpw_pkg::WS_IDLE;
                    end
                    else
                    begin
                        res_addr   = frame + {52'd0, vaddr_reg[20:12], 3'b000};
                        state_next = fpw_pkg::WS_L3;
                    end
                end
                fpw_pkg::WS_L3:
                begin
                    produce    = 1'b1;
                    res_done   = 1'b1;
                    state_next = fpw_pkg::WS_IDLE;
                    if (frame == 64'd0)
                    begin
                        res_fault = 1'b1;
                    end
                    else
                    begin
                        res_phys = sum_4k[51:0];
                    end
                end
                default:
                begin
                    state_next = fpw_pkg::WS_IDLE;
                end
            endcase
        end
    end

    assign q_pop      = q_valid && (!produce || out_free);
    assign load       = q_pop && produce;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpw_pkg::WS_IDLE;
            vaddr_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                state_reg <= state_next;
                vaddr_reg <= vaddr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            done_reg  <= res_done;
            addr_reg  <= res_addr;
            phys_reg  <= res_phys;
            fault_reg <= res_fault;
        end
    end

    assign result_valid = valid_reg;
    assign is_done      = done_reg;
    assign read_addr    = addr_reg;
    assign xlat_addr    = phys_reg;
    assign fault        = fault_reg;

    `FPW_ASSERT_SAME(a_fault_has_no_phys, clk, rst_n, valid_reg && fault_reg, done_reg && (phys_reg == '0))
    `FPW_ASSERT_SAME(a_read_is_clean, clk, rst_n, valid_reg && !done_reg, !fault_reg && (phys_reg == '0))
    `FPW_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, load && res_done, state_reg == fpw_pkg::WS_IDLE)
    `FPW_ASSERT_SAME(a_no_load_over_stall, clk, rst_n, valid_reg && result_stall, !load)

endmodule

// ===== src/four_level_page_walker_top.sv =====
// ----------------------------------------------------------------------------
// Four-level page walker top level
// Walks four-level page tables: translate requests start a walk, memory
// read responses advance it, and each step returns a read request or a
// finished translation.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while the four-entry queue
// has room, and the walk engine retires one queued transaction per cycle
// unless it is held. A transaction that produces a result waits for the
// result register to be free, while an ignored one leaves the queue at
// once. With an empty queue and a free result register, an accepted
// transaction is first written into the queue and is then loaded into the
// result register, which drives the output. Requests that arrive during a
// walk and responses that arrive while idle are dropped without a result.
module four_level_page_walker_top
#(
    parameter int PHYS_MASK_BITS = 36
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        op,
    input  logic [63:0] table_base,
    input  logic [47:0] virt_addr,
    input  logic [63:0] read_data,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        is_done,
    output logic [63:0] read_addr,
    output logic [51:0] xlat_addr,
    output logic        fault
);

    fpw_pkg::queue_status_t q_status;
    fpw_pkg::queue_item_t   push_item;
    fpw_pkg::queue_item_t   head_item;
    logic                   q_push;
    logic                   q_pop;

    fpw_front u_front
    (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .op         (op),
        .table_base (table_base),
        .virt_addr  (virt_addr),
        .read_data  (read_data),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    fpw_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .status    (q_status)
    );

    fpw_back
    #(
        .PHYS_MASK_BITS (PHYS_MASK_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_status.valid),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .is_done      (is_done),
        .read_addr    (read_addr),
        .xlat_addr    (xlat_addr),
        .fault        (fault)
    );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page walker testbench
// Runs a few directed walks that cover the edge cases, then random walks
// mixed with requests and responses that the walker must ignore. Each
// transaction has random gaps on both sides. An in-order model of the walk
// predicts every read request and every finished translation, and the
// monitor compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int PHYS_MASK_BITS = 36;
    localparam logic [63:0] ENTRY_FRAME_MASK =
        ((64'd1 << PHYS_MASK_BITS) - 64'd1) & ~64'hFFF;
    localparam logic [63:0] GIG_PAGE_FRAME = 64'h000F_FFFF_C000_0000;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam int WALK_ITEMS = 1650;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        fpw_pkg::op_t op;
        logic [63:0]  base;
        logic [47:0]  va;
        logic [63:0]  data;
    } walk_item_t;

    typedef struct {
        logic        done;
        logic [63:0] raddr;
        logic [51:0] paddr;
        logic        flt;
    } walk_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    fpw_pkg::op_t op = fpw_pkg::OP_TRANSLATE;
    logic [63:0]  table_base = '0;
    logic [47:0]  virt_addr = '0;
    logic [63:0]  read_data = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    logic         is_done;
    logic [63:0]  read_addr;
    logic [51:0]  xlat_addr;
    logic         fault;

    walk_item_t   pending_items[$];
    walk_result_t expected_steps[$];

    logic        walk_busy = 1'b0;
    logic [1:0]  walk_depth = '0;
    logic [47:0] latched_va = '0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned quiet_cycles = 0;
    int          walk_item_count = 0;

    four_level_page_walker_top #(.PHYS_MASK_BITS(PHYS_MASK_BITS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .op(op),
        .table_base(table_base),
        .virt_addr(virt_addr),
        .read_data(read_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .is_done(is_done),
        .read_addr(read_addr),
        .xlat_addr(xlat_addr),
        .fault(fault)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rnd48();
        return {16'($urandom_range(0, 16'hFFFF)), $urandom};
    endfunction

    function automatic logic take_break();
        if (cycle_count >= 700 && cycle_count < 1300)
        begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 18;
    endfunction

    task automatic add_item(input fpw_pkg::op_t o, input logic [63:0] b,
                            input logic [47:0] v, input logic [63:0] d);
        walk_item_t it;
        it.op = o;
        it.base = b;
        it.va = v;
        it.data = d;
        pending_items.push_back(it);
    endtask

    task automatic add_random_walk();
        int          lvl;
        logic [63:0] e;
        logic        ended;
        add_item(fpw_pkg::OP_TRANSLATE, rnd64(), rnd48(), rnd64());
        walk_item_count++;
        lvl = 0;
        ended = 1'b0;
        while (!ended)
        begin
            if ($urandom_range(0, 99) < 4)
            begin
                add_item(fpw_pkg::OP_TRANSLATE, rnd64(), rnd48(), rnd64());
            end
            e = rnd64();
            if (lvl < 3)
            begin
                e[0] = $urandom_range(0, 99) >= 8;
            end
            if (lvl == 1 || lvl == 2)
            begin
                e[7] = $urandom_range(0, 99) < 25;
            end
            if (lvl == 3 && $urandom_range(0, 99) < 10)
            begin
                e[35:12] = '0;
            end
            add_item(fpw_pkg::OP_RESPONSE, rnd64(), rnd48(), e);
            walk_item_count++;
            ended = (lvl == 3) || !e[0] || ((lvl == 1 || lvl == 2) && e[7]);
            lvl++;
        end
    endtask

    function automatic void predict_walk_step(input walk_item_t it);
        walk_result_t r;
        logic [63:0]  e;
        logic [63:0]  next_addr;
        logic [63:0]  phys;
        logic         ended;
        logic         flt;
        r.done = 1'b0;
        r.raddr = '0;
        r.paddr = '0;
        r.flt = 1'b0;
        e = it.data;
        if (it.op == fpw_pkg::OP_TRANSLATE)
        begin
            if (walk_busy)
            begin
                return;
            end
            latched_va = it.va;
            walk_busy = 1'b1;
            walk_depth = 2'd0;
            r.raddr = (it.base & ~64'hF) + {52'd0, latched_va[47:39], 3'b000};
            expected_steps.push_back(r);
            return;
        end
        if (!walk_busy)
        begin
            return;
        end
        ended = 1'b0;
        flt = 1'b0;
        phys = '0;
        next_addr = '0;
        case (walk_depth)
            2'd0:
            begin
                ended = !e[0];
                flt = !e[0];
                next_addr = (e & ENTRY_FRAME_MASK) + {52'd0, latched_va[38:30], 3'b000};
            end
            2'd1:
            begin
                ended = !e[0] || e[7];
                flt = !e[0];
                phys = (e & GIG_PAGE_FRAME) + {34'd0, latched_va[29:0]};
                next_addr = (e & ENTRY_FRAME_MASK) + {52'd0, latched_va[29:21], 3'b000};
            end
            2'd2:
            begin
                ended = !e[0] || e[7];
                flt = !e[0];
                phys = (e & ENTRY_FRAME_MASK) + {43'd0, latched_va[20:0]};
                next_addr = (e & ENTRY_FRAME_MASK) + {52'd0, latched_va[20:12], 3'b000};
            end
            default:
            begin
                ended = 1'b1;
                flt = (e & ENTRY_FRAME_MASK) == 64'd0;
                phys = (e & ENTRY_FRAME_MASK) + {52'd0, latched_va[11:0]};
            end
        endcase
        if (ended)
        begin
            walk_busy = 1'b0;
            walk_depth = 2'd0;
            r.done = 1'b1;
            r.flt = flt;
            r.paddr = flt ? 52'd0 : phys[51:0];
        end
        else
        begin
            walk_depth = walk_depth + 2'd1;
            r.raddr = next_addr;
        end
        expected_steps.push_back(r);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        walk_item_t it;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            op <= fpw_pkg::OP_TRANSLATE;
            table_base <= '0;
            virt_addr <= '0;
            read_data <= '0;
            result_stall <= 1'b0;
        end
        else
        begin
            result_stall <= take_break();
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 && !take_break())
                begin
                    it = pending_items.pop_front();
                    item_valid <= 1'b1;
                    op <= it.op;
                    table_base <= it.base;
                    virt_addr <= it.va;
                    read_data <= it.data;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        walk_item_t   it;
        walk_result_t exp_r;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (item_valid && !item_stall)
            begin
                it.op = op;
                it.base = table_base;
                it.va = virt_addr;
                it.data = read_data;
                predict_walk_step(it);
            end
            if (result_valid && !result_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    if (error_count < 10)
                    begin
                        $display("Unexpected transaction: done=%0b addr=%h phys=%h fault=%0b",
                                 is_done, read_addr, xlat_addr, fault);
                    end
                    error_count <= error_count + 1;
                end
                else
                begin
                    exp_r = expected_steps.pop_front();
                    if (is_done !== exp_r.done || read_addr !== exp_r.raddr ||
                        xlat_addr !== exp_r.paddr || fault !== exp_r.flt)
                    begin
                        if (error_count < 10)
                        begin
                            $display("Mismatch: expected done=%0b addr=%h phys=%h fault=%0b",
                                     exp_r.done, exp_r.raddr, exp_r.paddr, exp_r.flt);
                            $display("          actual   done=%0b addr=%h phys=%h fault=%0b",
                                     is_done, read_addr, xlat_addr, fault);
                        end
                        error_count <= error_count + 1;
                    end
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        add_item(fpw_pkg::OP_RESPONSE, ALL_ONES, {48{1'b1}}, ALL_ONES);
        add_item(fpw_pkg::OP_TRANSLATE, ALL_ONES, {48{1'b1}}, '0);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, ALL_ONES);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, ALL_ONES);
        add_item(fpw_pkg::OP_TRANSLATE, '0, '0, '0);
        add_item(fpw_pkg::OP_RESPONSE, ALL_ONES, {48{1'b1}}, '0);
        add_item(fpw_pkg::OP_TRANSLATE, 64'h0000_0000_0012_3450, {48{1'b1}}, '0);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_1001);
        add_item(fpw_pkg::OP_TRANSLATE, ALL_ONES, '0, ALL_ONES);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_2001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, ALL_ONES);
        add_item(fpw_pkg::OP_TRANSLATE, 64'h8000_0000_0000_0008, 48'h8000_0000_0000, '0);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h8000_000F_FFFF_F001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_3001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_4001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_0001);
        add_item(fpw_pkg::OP_TRANSLATE, '0, 48'h7FFF_FFFF_FFFF, '0);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_5001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_6001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_7001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE);
        add_item(fpw_pkg::OP_TRANSLATE, 64'h0000_0000_0000_F00F, 48'h0000_0000_0FFF, '0);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_8001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_9001);
        add_item(fpw_pkg::OP_RESPONSE, '0, '0, 64'h0000_0000_0000_A000);
        walk_item_count = 23;
        while (walk_item_count < WALK_ITEMS)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                add_item(fpw_pkg::OP_RESPONSE, rnd64(), rnd48(), rnd64());
            end
            add_random_walk();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !item_valid);
        wait (expected_steps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+src
src/fpw_pkg.sv
src/fpw_front.sv
src/fpw_queue.sv
src/fpw_back.sv
src/four_level_page_walker_top.sv
sim/tb.sv
